// File: design/tssd_pkg.sv
// ----------------------------------------------------------------------------
// Touch slider swipe detector package
// Shared types, codes and reset values for the swipe detector block.
// ----------------------------------------------------------------------------
package tssd_pkg;

  // Sensing channels that take part in the touch count.
  localparam int CHANNELS = 12;
  localparam int MASK_W   = 12;
  localparam int CNT_W    = $clog2(CHANNELS + 1);
  localparam int POS_W    = 16;
  localparam int STAMP_W  = 32;
  localparam int CFG_W    = 16;
  localparam int LIMIT_W  = 4;
  localparam int IDX_W    = 3;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_DOWN_START_X     = 3'd0;
  localparam logic [IDX_W-1:0] REG_UP_START_X       = 3'd1;
  localparam logic [IDX_W-1:0] REG_TRAVEL_THRESHOLD = 3'd2;
  localparam logic [IDX_W-1:0] REG_REARM_GAP_MS     = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_TOUCHED      = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0]   RST_DOWN_START_X     = 16'd600;
  localparam logic [CFG_W-1:0]   RST_UP_START_X       = 16'd200;
  localparam logic [CFG_W-1:0]   RST_TRAVEL_THRESHOLD = 16'd400;
  localparam logic [CFG_W-1:0]   RST_REARM_GAP_MS     = 16'd150;
  localparam logic [LIMIT_W-1:0] RST_MAX_TOUCHED      = 4'd3;

  localparam logic [POS_W-1:0] TRAVEL_MAX = '1;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    KEY_NONE       = 2'd0,
    KEY_SLIDE_UP   = 2'd1,
    KEY_SLIDE_DOWN = 2'd2
  } key_t;

  // Configuration register set.
  typedef struct packed {
    logic [CFG_W-1:0]   down_start_x;
    logic [CFG_W-1:0]   up_start_x;
    logic [CFG_W-1:0]   travel_threshold;
    logic [CFG_W-1:0]   rearm_gap_ms;
    logic [LIMIT_W-1:0] max_touched;
  } cfg_t;

  // Gesture state carried from one sample to the next.
  typedef struct packed {
    logic               armed;
    dir_t               direction;
    logic [POS_W-1:0]   travel;
    logic [POS_W-1:0]   last_x;
    logic [STAMP_W-1:0] last_stamp;
  } gesture_t;

  // One input word.
  typedef struct packed {
    logic [POS_W-1:0]   position_x;
    logic [MASK_W-1:0]  touch_mask;
    logic [STAMP_W-1:0] stamp_ms;
  } sample_t;

  // One result word.
  typedef struct packed {
    key_t             key_event;
    dir_t             swipe_dir;
    logic [POS_W-1:0] travel_now;
    logic             is_armed;
  } result_t;

endpackage

// File: design/tssd_cfg.sv
// ----------------------------------------------------------------------------
// Swipe detector configuration registers
// Holds the five thresholds, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module tssd_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [tssd_pkg::IDX_W-1:0]  cfg_index,
  input  logic [tssd_pkg::CFG_W-1:0]  cfg_wdata,
  output tssd_pkg::cfg_t              cfg
);

  // Register file; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.down_start_x     <= tssd_pkg::RST_DOWN_START_X;
      cfg.up_start_x       <= tssd_pkg::RST_UP_START_X;
      cfg.travel_threshold <= tssd_pkg::RST_TRAVEL_THRESHOLD;
      cfg.rearm_gap_ms     <= tssd_pkg::RST_REARM_GAP_MS;
      cfg.max_touched      <= tssd_pkg::RST_MAX_TOUCHED;
    end else if (cfg_we) begin
      case (cfg_index)
        tssd_pkg::REG_DOWN_START_X:     cfg.down_start_x     <= cfg_wdata;
        tssd_pkg::REG_UP_START_X:       cfg.up_start_x       <= cfg_wdata;
        tssd_pkg::REG_TRAVEL_THRESHOLD: cfg.travel_threshold <= cfg_wdata;
        tssd_pkg::REG_REARM_GAP_MS:     cfg.rearm_gap_ms     <= cfg_wdata;
        tssd_pkg::REG_MAX_TOUCHED: begin
          cfg.max_touched <= cfg_wdata[tssd_pkg::LIMIT_W-1:0];
        end
        default: ;
      endcase
    end
  end

endmodule

// File: design/tssd_step.sv
// ----------------------------------------------------------------------------
// Swipe detector step logic
// Combinational update of the gesture state for one sample.
// ----------------------------------------------------------------------------
module tssd_step (
  input  tssd_pkg::cfg_t     cfg,
  input  tssd_pkg::gesture_t st,
  input  tssd_pkg::sample_t  smp,
  output tssd_pkg::gesture_t st_next,
  output tssd_pkg::result_t  res
);

  logic [tssd_pkg::CNT_W-1:0]   touch_cnt;
  logic                         too_many;
  logic [tssd_pkg::STAMP_W-1:0] gap;
  logic                         gap_long;
  logic [tssd_pkg::POS_W-1:0]   x;
  logic [tssd_pkg::POS_W-1:0]   rise;
  logic [tssd_pkg::POS_W-1:0]   fall;
  logic [tssd_pkg::POS_W:0]     sum_up;
  logic [tssd_pkg::POS_W:0]     sum_down;
  logic [tssd_pkg::POS_W-1:0]   sat_up;
  logic [tssd_pkg::POS_W-1:0]   sat_down;
  tssd_pkg::key_t               key;

  assign x = smp.position_x;

  // Count the touched channels.
  always_comb begin
    touch_cnt = '0;
    for (int i = 0; i < tssd_pkg::CHANNELS && i < tssd_pkg::MASK_W; i++) begin
      touch_cnt = touch_cnt + tssd_pkg::CNT_W'(smp.touch_mask[i]);
    end
  end

  assign too_many = ({1'b0, touch_cnt} > (tssd_pkg::CNT_W + 1)'(cfg.max_touched));

  // Sample gap, modulo the stamp width.
  assign gap      = smp.stamp_ms - st.last_stamp;
  assign gap_long = (gap > tssd_pkg::STAMP_W'(cfg.rearm_gap_ms));

  // Motion since the previous sample and saturated travel sums.
  assign rise     = x - st.last_x;
  assign fall     = st.last_x - x;
  assign sum_up   = {1'b0, st.travel} + {1'b0, rise};
  assign sum_down = {1'b0, st.travel} + {1'b0, fall};
  assign sat_up   = sum_up[tssd_pkg::POS_W] ? tssd_pkg::TRAVEL_MAX
                                            : sum_up[tssd_pkg::POS_W-1:0];
  assign sat_down = sum_down[tssd_pkg::POS_W] ? tssd_pkg::TRAVEL_MAX
                                              : sum_down[tssd_pkg::POS_W-1:0];

  // Gesture decision.
  always_comb begin
    st_next            = st;
    st_next.last_x     = x;
    st_next.last_stamp = smp.stamp_ms;
    key                = tssd_pkg::KEY_NONE;

    if (too_many) begin
      st_next.armed     = 1'b0;
      st_next.direction = tssd_pkg::DIR_NONE;
      st_next.travel    = '0;
    end else if (gap_long) begin
      st_next.armed     = 1'b1;
      st_next.direction = tssd_pkg::DIR_NONE;
      st_next.travel    = '0;
    end else if (st.armed) begin
      case (st.direction)
        tssd_pkg::DIR_NONE: begin
          if (st.last_x > cfg.down_start_x && st.last_x > x) begin
            st_next.direction = tssd_pkg::DIR_DOWN;
            st_next.travel    = fall;
          end else if (st.last_x < cfg.up_start_x && x > st.last_x) begin
            st_next.direction = tssd_pkg::DIR_UP;
            st_next.travel    = rise;
          end
        end
        tssd_pkg::DIR_UP: begin
          if (x >= st.last_x) begin
            st_next.travel = sat_up;
          end else begin
            st_next.armed     = 1'b0;
            st_next.direction = tssd_pkg::DIR_NONE;
            st_next.travel    = '0;
          end
        end
        tssd_pkg::DIR_DOWN: begin
          if (st.last_x >= x) begin
            st_next.travel = sat_down;
          end else begin
            st_next.armed     = 1'b0;
            st_next.direction = tssd_pkg::DIR_NONE;
            st_next.travel    = '0;
          end
        end
        default: ;
      endcase

      // Enough travel in a known direction fires the key and disarms.
      if (st_next.travel > cfg.travel_threshold) begin
        if (st_next.direction == tssd_pkg::DIR_UP) begin
          key           = tssd_pkg::KEY_SLIDE_UP;
          st_next.armed = 1'b0;
        end else if (st_next.direction == tssd_pkg::DIR_DOWN) begin
          key           = tssd_pkg::KEY_SLIDE_DOWN;
          st_next.armed = 1'b0;
        end
      end
    end
  end

  assign res.key_event  = key;
  assign res.swipe_dir  = st_next.direction;
  assign res.travel_now = st_next.travel;
  assign res.is_armed   = st_next.armed;

endmodule

// File: design/touch_slider_swipe_detector_unit.sv
// ----------------------------------------------------------------------------
// Touch slider swipe detector
// Turns slider samples into slide-up and slide-down key events.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (position_x, touch_mask, stamp_ms) enter on in_valid and
//   in_ready. Each word yields exactly one result word (key_event,
//   swipe_dir, travel_now, is_armed) on out_valid and out_ready.
//   A word is captured in an input register; from there the step logic
//   updates the gesture state and loads the result register as soon as
//   that register is free or draining, so every result passes both registers.
//   One word is taken every cycle while results are drained; the step
//   logic is a single pass of a popcount, a 32-bit gap compare and a
//   16-bit saturating add.
//   When the receiver stalls, the result register holds its word and the
//   input register holds one more; in_ready then drops until out_ready
//   returns.
//   Reset clears the gesture state (not armed, no direction, zero travel,
//   previous x and time zero), empties both registers and loads the
//   default thresholds. Configuration writes via cfg_we, cfg_index and
//   cfg_wdata take effect at once and belong in idle periods.
// ----------------------------------------------------------------------------
module touch_slider_swipe_detector_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tssd_pkg::IDX_W-1:0]    cfg_index,
  input  logic [tssd_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tssd_pkg::POS_W-1:0]    position_x,
  input  logic [tssd_pkg::MASK_W-1:0]   touch_mask,
  input  logic [tssd_pkg::STAMP_W-1:0]  stamp_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    key_event,
  output logic [1:0]                    swipe_dir,
  output logic [tssd_pkg::POS_W-1:0]    travel_now,
  output logic                          is_armed
);

  tssd_pkg::cfg_t     cfg;
  tssd_pkg::gesture_t st;
  tssd_pkg::gesture_t st_next;
  tssd_pkg::sample_t  smp;
  tssd_pkg::result_t  res_next;
  tssd_pkg::result_t  res;
  logic               smp_valid;
  logic               advance;

  tssd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tssd_step u_step (
    .cfg     (cfg),
    .st      (st),
    .smp     (smp),
    .st_next (st_next),
    .res     (res_next)
  );

  // The held word moves on when the result register is free or draining.
  assign advance  = smp_valid && (!out_valid || out_ready);
  assign in_ready = !smp_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (in_ready) begin
      smp_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      smp.position_x <= position_x;
      smp.touch_mask <= touch_mask;
      smp.stamp_ms   <= stamp_ms;
    end
  end

  // Gesture state, updated once per word that reaches the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.armed      <= 1'b0;
      st.direction  <= tssd_pkg::DIR_NONE;
      st.travel     <= '0;
      st.last_x     <= '0;
      st.last_stamp <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  assign key_event  = res.key_event;
  assign swipe_dir  = res.swipe_dir;
  assign travel_now = res.travel_now;
  assign is_armed   = res.is_armed;

endmodule
